// ----- src/refcounted_slot_cache_macros.svh -----
// ----------------------------------------------------------------------------
// refcounted_slot_cache_macros
// Assertion macros for the slot cache. Each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_SLOT_CACHE_MACROS_SVH
`define REFCOUNTED_SLOT_CACHE_MACROS_SVH

// Same-cycle implication.
`define RSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot cache assertion failed");

// Next-cycle implication.
`define RSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot cache assertion failed");

`endif

// ----- src/rsc_pkg.sv -----
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared constants and beat types of the reference-counted slot cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  localparam int SLOT_COUNT     = 40;
  localparam int TILES_PER_SLOT = 16;
  localparam int KEY_BITS       = 16;

  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int USES_W = 8;
  localparam logic [USES_W-1:0] USES_MAX = '1;

  localparam int IN_KEY_W   = 16;
  localparam int SLOT_FLD_W = 6;
  localparam int TILE_FLD_W = 10;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [IN_KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [SLOT_FLD_W-1:0] slot_index;
    logic [TILE_FLD_W-1:0] tile_base;
    logic                  slot_freed;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/refcounted_slot_cache.sv -----
// ----------------------------------------------------------------------------
// refcounted_slot_cache
// Reference-counted slot allocator over a two-port table of key/count entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// A request beat is taken when start is high and busy is low. Each request
// yields exactly one response beat on out_rsp, flagged by out_valid for a
// single cycle; the receiver cannot stall, so capture it on that edge. A
// request with key zero answers in the next cycle and leaves busy low. Any
// other request scans the whole slot table through the table's single read
// port, one entry a cycle, then writes the chosen entry back, if there is
// one: busy stays high through the scan, drain and finish states, and the
// response appears in the same cycle that busy falls. The table comes up
// empty right after reset with no clearing pass: per-entry valid flops make
// unwritten slots read as free.
module refcounted_slot_cache (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  rsc_pkg::req_t     in_req,
  output logic              out_valid,
  output rsc_pkg::rsp_t     out_rsp
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int ENT_W = rsc_pkg::KEY_BITS + rsc_pkg::USES_W;
  localparam logic [rsc_pkg::IDX_W-1:0] LAST_IDX =
    rsc_pkg::IDX_W'(rsc_pkg::SLOT_COUNT - 1);

  // --------------------------------------------------------------------------
  // Slot table: key in the upper bits, use count in the lower bits.
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0]                mem [rsc_pkg::SLOT_COUNT];
  logic                            mem_we;
  logic [rsc_pkg::IDX_W-1:0]       mem_wa;
  logic [ENT_W-1:0]                mem_wd;
  logic [rsc_pkg::IDX_W-1:0]       mem_ra;
  logic [ENT_W-1:0]                rd_data_r;

  // One valid flop per slot; a slot never written reads as free.
  logic [rsc_pkg::SLOT_COUNT-1:0]  vld_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
      rd_vld_r <= vld_r[mem_ra];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [1:0]                    state_r, state_nxt;
  logic [rsc_pkg::IDX_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic [rsc_pkg::IDX_W-1:0]     rd_idx_r;
  logic                          rd_pend_r, rd_pend_nxt;
  logic                          req_type_r, req_type_nxt;
  logic [rsc_pkg::KEY_BITS-1:0]  key_r, key_nxt;

  logic                          hit_found_r, hit_found_nxt;
  logic [rsc_pkg::IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [rsc_pkg::USES_W-1:0]    hit_uses_r, hit_uses_nxt;
  logic                          free_found_r, free_found_nxt;
  logic [rsc_pkg::IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic [rsc_pkg::USES_W-1:0]    free_uses_r, free_uses_nxt;

  logic                          out_valid_r, out_valid_nxt;
  rsc_pkg::rsp_t                 out_rsp_r, out_rsp_nxt;

  // Entry as returned by the read port, forced to free when never written.
  logic [rsc_pkg::KEY_BITS-1:0]  eff_key;
  logic [rsc_pkg::USES_W-1:0]    eff_uses;

  // Write-back helpers for the finish step.
  logic [rsc_pkg::IDX_W-1:0]     tgt_idx;
  logic [rsc_pkg::USES_W-1:0]    tgt_uses;
  logic [rsc_pkg::USES_W-1:0]    dec_uses;
  logic [rsc_pkg::KEY_BITS-1:0]  in_key;
  logic [31:0]                   tile_full;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign in_key   = rsc_pkg::KEY_BITS'(in_req.key);
  assign eff_key  = rd_vld_r ? rd_data_r[ENT_W-1 -: rsc_pkg::KEY_BITS] : '0;
  assign eff_uses = rd_vld_r ? rd_data_r[rsc_pkg::USES_W-1:0] : '0;

  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    rd_pend_nxt    = 1'b0;
    req_type_nxt   = req_type_r;
    key_nxt        = key_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_uses_nxt   = hit_uses_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    free_uses_nxt  = free_uses_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_ra         = scan_addr_r;
    tgt_idx        = '0;
    tgt_uses       = '0;
    dec_uses       = '0;
    tile_full      = '0;

    // Fold each returned entry into the first-hit and first-free trackers.
    if (rd_pend_r) begin
      if (!hit_found_r && eff_key == key_r) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = rd_idx_r;
        hit_uses_nxt  = eff_uses;
      end
      if (!free_found_r && eff_key == '0) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
        free_uses_nxt  = eff_uses;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_type_nxt   = in_req.req_type;
          key_nxt        = in_key;
          hit_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          scan_addr_nxt  = '0;
          if (in_key == '0) begin
            // Reject key zero at once; the table is left alone.
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = '0;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle; data lands in the next cycle.
        rd_pend_nxt = 1'b1;
        if (scan_addr_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end

      ST_DRAIN: begin
        // The last entry is folded in above.
        state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '0;
        if (req_type_r == rsc_pkg::REQ_ACQUIRE) begin
          if (hit_found_r || free_found_r) begin
            tgt_idx   = hit_found_r ? hit_idx_r : free_idx_r;
            tgt_uses  = hit_found_r ? hit_uses_r : free_uses_r;
            tile_full = 32'(tgt_idx) * 32'(rsc_pkg::TILES_PER_SLOT);
            mem_we    = 1'b1;
            mem_wa    = tgt_idx;
            mem_wd    = {key_r, (tgt_uses == rsc_pkg::USES_MAX) ?
                                tgt_uses : tgt_uses + 1'b1};
            out_rsp_nxt.ok         = 1'b1;
            out_rsp_nxt.slot_index = rsc_pkg::SLOT_FLD_W'(tgt_idx);
            out_rsp_nxt.tile_base  = tile_full[rsc_pkg::TILE_FLD_W-1:0];
          end
        end else if (hit_found_r) begin
          // Drop one use; free the slot when none remain.
          dec_uses = (hit_uses_r == '0) ? '0 : hit_uses_r - 1'b1;
          mem_we   = 1'b1;
          mem_wa   = hit_idx_r;
          if (dec_uses == '0) begin
            mem_wd                 = '0;
            out_rsp_nxt.slot_freed = 1'b1;
          end else begin
            mem_wd = {key_r, dec_uses};
          end
          out_rsp_nxt.ok         = 1'b1;
          out_rsp_nxt.slot_index = rsc_pkg::SLOT_FLD_W'(hit_idx_r);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      scan_addr_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_valid_r  <= out_valid_nxt;
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
      scan_addr_r  <= scan_addr_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    rd_idx_r    <= scan_addr_r;
    req_type_r  <= req_type_nxt;
    key_r       <= key_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_uses_r  <= hit_uses_nxt;
    free_idx_r  <= free_idx_nxt;
    free_uses_r <= free_uses_nxt;
    out_rsp_r   <= out_rsp_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`include "refcounted_slot_cache_macros.svh"

  // A nonzero-key request always starts a table scan.
  `RSC_ASSERT_NXT(a_scan_on_accept, start && !busy && in_key != '0, state_r == ST_SCAN)
  // The finish step always produces its response beat.
  `RSC_ASSERT_NXT(a_finish_responds, state_r == ST_FINISH, out_valid && !busy)
  // A failed request reports all-zero fields.
  `RSC_ASSERT_IMP(a_fail_zero, out_valid && !out_rsp.ok, out_rsp == '0)
  // Only the finish step writes the table.
  `RSC_ASSERT_IMP(a_write_only_finish, mem_we, state_r == ST_FINISH)

endmodule

`default_nettype wire

// ----- tb/tb_refcounted_slot_cache.sv -----
// ----------------------------------------------------------------------------
// tb_refcounted_slot_cache
// Self-checking bench for the reference-counted slot cache. A negedge driver
// feeds request beats from a backlog with random gaps. A posedge monitor
// predicts each accepted request against a private slot table and checks
// every response beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_refcounted_slot_cache;
  import rsc_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int POOL_SIZE  = 48;   // more keys than slots, so the table fills up
  localparam int CHUNKS     = 5;
  localparam int CHUNK_LEN  = 96;
  localparam int DRAIN_MAX  = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  rsp_t out_rsp;

  refcounted_slot_cache dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Private copy of the slot table, cleared once at the start of simulation.
  logic [IN_KEY_W-1:0] held_key [SLOT_COUNT];
  logic [USES_W-1:0]   use_count [SLOT_COUNT];

  req_t req_backlog [$];
  rsp_t expected_rsp [$];

  int mismatch_count = 0;
  int acq_granted = 0;
  int acq_refused = 0;
  int rel_matched = 0;
  int rel_unknown = 0;
  int slots_freed = 0;
  int zero_keys = 0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      held_key[i]  = '0;
      use_count[i] = '0;
    end
  end

  // Work out the response of one request and update the private table.
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    logic [IN_KEY_W-1:0] k;
    int hit;
    res = '0;
    k = IN_KEY_W'(r.key[KEY_BITS-1:0]);
    hit = -1;
    if (k == '0) begin
      // zero key is rejected either way, table untouched
      zero_keys++;
      return res;
    end
    for (int i = 0; i < SLOT_COUNT; i++)
      if (hit < 0 && held_key[i] == k) hit = i;
    if (r.req_type == REQ_ACQUIRE) begin
      // not held yet: take the lowest free slot
      if (hit < 0)
        for (int i = 0; i < SLOT_COUNT; i++)
          if (hit < 0 && held_key[i] == '0) hit = i;
      if (hit < 0) begin
        // table full
        acq_refused++;
        return res;
      end
      held_key[hit] = k;
      if (use_count[hit] < USES_MAX) use_count[hit] = use_count[hit] + 1'b1;
      res.ok = 1'b1;
      res.slot_index = SLOT_FLD_W'(hit);
      res.tile_base = TILE_FLD_W'(hit * TILES_PER_SLOT);
      acq_granted++;
      return res;
    end
    if (hit < 0) begin
      rel_unknown++;
      return res;
    end
    if (use_count[hit] > 0) use_count[hit] = use_count[hit] - 1'b1;
    res.ok = 1'b1;
    res.slot_index = SLOT_FLD_W'(hit);
    rel_matched++;
    if (use_count[hit] == '0) begin
      held_key[hit] = '0;
      res.slot_freed = 1'b1;
      slots_freed++;
    end
    return res;
  endfunction

  // Gap before the next request: mostly short, a few long, with runs of none.
  int steady_left = 0;

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(15, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_req(logic kind, logic [IN_KEY_W-1:0] k);
    req_t r;
    r.req_type = kind;
    r.key = k;
    req_backlog.push_back(r);
  endtask

  // Fill every slot with distinct keys, bounce one more off the full table,
  // then release them all.
  task automatic fill_and_drain();
    logic [IN_KEY_W-1:0] base;
    base = IN_KEY_W'($urandom_range(1, 65535 - SLOT_COUNT - 1));
    for (int i = 0; i < SLOT_COUNT; i++) queue_req(REQ_ACQUIRE, base + IN_KEY_W'(i));
    queue_req(REQ_ACQUIRE, base + IN_KEY_W'(SLOT_COUNT));
    queue_req(REQ_ACQUIRE, base + IN_KEY_W'($urandom_range(0, SLOT_COUNT - 1)));
    queue_req(REQ_RELEASE, base + IN_KEY_W'(SLOT_COUNT));
    for (int i = SLOT_COUNT - 1; i >= 0; i--) queue_req(REQ_RELEASE, base + IN_KEY_W'(i));
    // one key was acquired twice above
    for (int i = 0; i < SLOT_COUNT; i++) queue_req(REQ_RELEASE, base + IN_KEY_W'(i));
  endtask

  // Driver: change inputs at the falling edge, hold a beat until it is taken.
  logic beat_taken = 1'b0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !beat_taken) begin
        // hold: beat not taken yet
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_backlog.size() > 0) begin
        in_req <= req_backlog.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: sample at the rising edge, check responses, predict new requests.
  rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= start && !busy;
      if (out_valid) begin
        if (expected_rsp.size() == 0) begin
          $error("response beat with no request outstanding: %p", out_rsp);
          mismatch_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_rsp.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_rsp.ok);
            mismatch_count++;
          end
          if (out_rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_rsp.slot_index);
            mismatch_count++;
          end
          if (out_rsp.tile_base !== want.tile_base) begin
            $error("tile_base: expected %0d, got %0d", want.tile_base, out_rsp.tile_base);
            mismatch_count++;
          end
          if (out_rsp.slot_freed !== want.slot_freed) begin
            $error("slot_freed: expected %0d, got %0d", want.slot_freed, out_rsp.slot_freed);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) expected_rsp.push_back(apply_request(in_req));
    end
  end

  // Stimulus and end of run.
  logic [IN_KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    int acq_pct;
    int r;
    int guard;
    logic [IN_KEY_W-1:0] k;
    logic kind;

    // Directed: zero key both ways, unknown release, extreme keys, slot reuse.
    queue_req(REQ_ACQUIRE, 16'h0000);
    queue_req(REQ_RELEASE, 16'h0000);
    queue_req(REQ_RELEASE, 16'h1234);
    queue_req(REQ_ACQUIRE, 16'hFFFF);
    queue_req(REQ_ACQUIRE, 16'h0001);
    queue_req(REQ_ACQUIRE, 16'hFFFF);
    queue_req(REQ_ACQUIRE, 16'h8000);
    queue_req(REQ_RELEASE, 16'h0001);
    queue_req(REQ_ACQUIRE, 16'h7FFF);
    queue_req(REQ_RELEASE, 16'hFFFF);
    queue_req(REQ_RELEASE, 16'hFFFF);
    queue_req(REQ_RELEASE, 16'hFFFF);
    queue_req(REQ_ACQUIRE, 16'h5555);
    queue_req(REQ_ACQUIRE, 16'hAAAA);
    queue_req(REQ_ACQUIRE, 16'h0000);
    queue_req(REQ_RELEASE, 16'h8000);
    queue_req(REQ_RELEASE, 16'h7FFF);
    queue_req(REQ_RELEASE, 16'h5555);
    queue_req(REQ_RELEASE, 16'hAAAA);
    queue_req(REQ_RELEASE, 16'h5555);

    // Table full, then the count saturating at its top and draining back down.
    fill_and_drain();
    k = IN_KEY_W'($urandom_range(1, 65535));
    for (int i = 0; i < int'(USES_MAX) + 2; i++) queue_req(REQ_ACQUIRE, k);
    for (int i = 0; i < int'(USES_MAX) + 1; i++) queue_req(REQ_RELEASE, k);

    // Random: pool keys with a per-chunk acquire bias so the table fills and
    // drains repeatedly; a few zero and fully random keys mixed in.
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = IN_KEY_W'($urandom_range(1, 65535));
    key_pool[0] = 16'hFFFF;
    key_pool[1] = 16'h0001;
    for (int c = 0; c < CHUNKS; c++) begin
      acq_pct = (c == 0) ? 90 : $urandom_range(25, 85);
      for (int j = 0; j < CHUNK_LEN; j++) begin
        r = $urandom_range(0, 99);
        if (r < 4) k = '0;
        else if (r < 10) k = IN_KEY_W'($urandom_range(0, 65535));
        else k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        kind = ($urandom_range(0, 99) < acq_pct) ? REQ_ACQUIRE : REQ_RELEASE;
        queue_req(kind, k);
      end
      if (c == CHUNKS / 2) fill_and_drain();
    end

    // Synchronous reset, released at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last beat to be taken, then for its response.
    wait (req_backlog.size() == 0 && !start);
    guard = 0;
    while (expected_rsp.size() > 0 && guard < DRAIN_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (SLOT_COUNT + 8) @(posedge clk);
    if (expected_rsp.size() != 0) begin
      $error("%0d responses never arrived", expected_rsp.size());
      mismatch_count++;
    end

    $display("covered %0d acquires granted, %0d refused on a full table, %0d zero keys",
             acq_granted, acq_refused, zero_keys);
    $display("covered %0d releases matched (%0d freed a slot), %0d of unknown keys",
             rel_matched, slots_freed, rel_unknown);
    if (mismatch_count == 0) begin
      $display("tb_refcounted_slot_cache passed");
    end else begin
      $display("tb_refcounted_slot_cache failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb_refcounted_slot_cache failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/rsc_pkg.sv
src/refcounted_slot_cache.sv
tb/tb_refcounted_slot_cache.sv
